[hdl/ecrp_pkg.sv]
// Shared types and constants for the encoder-checked rotary positioner.
// No dependencies; every other file in hdl/ imports this package.
package ecrp_pkg;

	localparam int PosW    = 12;
	localparam int GoalW   = 13;
	localparam int FrameW  = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 16;

	localparam logic [PosW-1:0] ScaleOffset = 12'd128;
	// wrap bounds: 350 and 10 degrees in 1/4096 rev
	localparam logic [PosW-1:0] WrapHiMin = 12'd3983;
	localparam logic [PosW-1:0] WrapLoMax = 12'd113;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	localparam logic [CfgIdxW-1:0] CFG_PURGE    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_CW_SLIP  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_CCW_SLIP = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MAX_FAIL = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_MOVING    = 3'd1,
		ST_ARRIVED   = 3'd2,
		ST_BAD_START = 3'd3,
		ST_ENC_LOST  = 3'd4,
		ST_TIMEOUT   = 3'd5
	} status_t;

	typedef struct packed {
		logic [11:0] purge_position;
		logic [9:0]  cw_slip;
		logic [9:0]  ccw_slip;
		logic [7:0]  max_failures;
		logic [15:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [PosW-1:0]         current_position;
		logic signed [7:0]       turns;
		logic [7:0]              failure_count;
		logic [15:0]             elapsed_ms;
		logic signed [GoalW-1:0] adapted_goal;
		logic                    moving;
		logic                    heading_cw;
	} state_t;

	typedef struct packed {
		status_t                status;
		logic                   motor_on;
		logic                   direction_cw;
		logic signed [PosW-1:0] scaled_position;
		logic signed [7:0]      turn_count;
	} result_t;

endpackage

[hdl/ecrp_frame_check.sv]
// Encoder frame decode: two odd-parity check groups and the 12-bit angle.
// Depends on ecrp_pkg.
module ecrp_frame_check (
	input  logic [15:0] frame,
	output logic        good,
	output logic [11:0] pos
);
	import ecrp_pkg::*;

	// bit 15 covers the odd bits, bit 14 the even bits; each group is odd parity
	assign good = (^(frame & 16'hAAAA)) & (^(frame & 16'h5555));
	assign pos  = frame[13:2];

endmodule

[hdl/ecrp_next_state.sv]
// Next-state and result logic for one request, purely combinational.
// Depends on ecrp_pkg and ecrp_frame_check.
module ecrp_next_state (
	input  ecrp_pkg::cfg_t    cfg,
	input  ecrp_pkg::state_t  st,
	input  logic [1:0]        mode,
	input  logic [15:0]       frame,
	input  logic [11:0]       target_position,
	output ecrp_pkg::state_t  nxt,
	output ecrp_pkg::result_t res
);
	import ecrp_pkg::*;

	logic                    good;
	logic [PosW-1:0]         pos;
	logic signed [PosW-1:0]  sg;
	logic signed [PosW-1:0]  sp;
	logic signed [PosW-1:0]  sa;
	logic signed [PosW-1:0]  sc;
	logic signed [GoalW-1:0] diff;
	logic                    head;
	status_t                 status;

	function automatic logic signed [PosW-1:0] scale_pos(input logic [PosW-1:0] a,
			input logic [PosW-1:0] purge);
		logic [PosW-1:0] s;
		s = a - purge + ScaleOffset;
		return signed'(s);
	endfunction

	ecrp_frame_check u_frame (
		.frame (frame),
		.good  (good),
		.pos   (pos)
	);

	assign sg   = scale_pos(target_position, cfg.purge_position);
	assign sp   = scale_pos(pos, cfg.purge_position);
	assign diff = GoalW'(sg) - GoalW'(sp);
	assign head = ~diff[GoalW-1];

	// arrival check position for a sample: new frame if good, else the held one
	assign sa = scale_pos(good ? pos : st.current_position, cfg.purge_position);

	always_comb begin
		nxt    = st;
		status = st.moving ? ST_MOVING : ST_IDLE;
		case (mode)
			MODE_START: begin
				nxt.turns         = '0;
				nxt.failure_count = '0;
				nxt.elapsed_ms    = '0;
				if (!good) begin
					nxt.moving = 1'b0;
					status     = ST_BAD_START;
				end else begin
					nxt.current_position = pos;
					nxt.heading_cw       = head;
					nxt.adapted_goal     = head
						? GoalW'(sg) - signed'(GoalW'(cfg.cw_slip))
						: GoalW'(sg) + signed'(GoalW'(cfg.ccw_slip));
					nxt.moving = 1'b1;
					status     = ST_MOVING;
				end
			end
			MODE_SAMPLE: begin
				if (st.moving) begin
					if (good) begin
						nxt.current_position = pos;
						nxt.failure_count    = '0;
						if (pos >= WrapHiMin && st.current_position <= WrapLoMax) begin
							if (st.turns != -8'sd127) nxt.turns = st.turns - 8'sd1;
						end else if (pos <= WrapLoMax && st.current_position >= WrapHiMin) begin
							if (st.turns != 8'sd127) nxt.turns = st.turns + 8'sd1;
						end
					end else if (st.failure_count != 8'hFF) begin
						nxt.failure_count = st.failure_count + 8'd1;
					end
					status = ST_MOVING;
					if (nxt.failure_count >= cfg.max_failures) begin
						nxt.moving = 1'b0;
						status     = ST_ENC_LOST;
					end else if (st.elapsed_ms > cfg.timeout_ms) begin
						nxt.moving = 1'b0;
						status     = ST_TIMEOUT;
					end else if ((st.heading_cw && GoalW'(sa) >= st.adapted_goal) ||
							(!st.heading_cw && GoalW'(sa) <= st.adapted_goal)) begin
						nxt.moving = 1'b0;
						status     = ST_ARRIVED;
					end
				end
			end
			MODE_TICK: begin
				if (st.moving) begin
					if (st.elapsed_ms != 16'hFFFF) nxt.elapsed_ms = st.elapsed_ms + 16'd1;
					status = ST_MOVING;
					if (nxt.elapsed_ms > cfg.timeout_ms) begin
						nxt.moving = 1'b0;
						status     = ST_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// position after this request (held position when the frame was bad)
	assign sc = scale_pos(nxt.current_position, cfg.purge_position);

	assign res.status          = status;
	assign res.motor_on        = nxt.moving;
	assign res.direction_cw    = nxt.heading_cw;
	assign res.scaled_position = sc;
	assign res.turn_count      = nxt.turns;

endmodule

[hdl/ecrp_out_buf.sv]
// Result register with one skid entry so input accept does not wait on out_ready.
// Depends on ecrp_pkg.
module ecrp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ecrp_pkg::result_t push_data,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output ecrp_pkg::result_t out_data
);
	import ecrp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;

	assign can_push  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

[hdl/encoder_checked_rotary_positioner.sv]
// Rotary positioner top: config registers, move state and result buffer.
// An accepted request's result is registered in the result register, or in the skid entry while out_* stalls.
// Throughput: one request per cycle while in_ready is high; the state update is a single combinational pass.
// in_ready drops only while both result register and skid entry hold results.
// Reset (arst_n low, asynchronous): config to defaults, motor stopped, heading cw.
// Depends on ecrp_pkg, ecrp_next_state, ecrp_frame_check, ecrp_out_buf.
module encoder_checked_rotary_positioner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [15:0]         frame,
	input  logic [11:0]         target_position,
	output logic                out_valid,
	input  logic                out_ready,
	output ecrp_pkg::status_t   status,
	output logic                motor_on,
	output logic                direction_cw,
	output logic signed [11:0]  scaled_position,
	output logic signed [7:0]   turn_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import ecrp_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t out_data;
	logic    accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.purge_position <= 12'd0;
			cfg_q.cw_slip        <= 10'd59;
			cfg_q.ccw_slip       <= 10'd0;
			cfg_q.max_failures   <= 8'd10;
			cfg_q.timeout_ms     <= 16'd10000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PURGE:    cfg_q.purge_position <= cfg_data[11:0];
				CFG_CW_SLIP:  cfg_q.cw_slip        <= cfg_data[9:0];
				CFG_CCW_SLIP: cfg_q.ccw_slip       <= cfg_data[9:0];
				CFG_MAX_FAIL: cfg_q.max_failures   <= cfg_data[7:0];
				CFG_TIMEOUT:  cfg_q.timeout_ms     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ecrp_next_state u_next (
		.cfg             (cfg_q),
		.st              (state_q),
		.mode            (mode),
		.frame           (frame),
		.target_position (target_position),
		.nxt             (state_nxt),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{current_position: '0, turns: '0, failure_count: '0,
				elapsed_ms: '0, adapted_goal: '0, moving: 1'b0, heading_cw: 1'b1};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	ecrp_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign status          = out_data.status;
	assign motor_on        = out_data.motor_on;
	assign direction_cw    = out_data.direction_cw;
	assign scaled_position = out_data.scaled_position;
	assign turn_count      = out_data.turn_count;

endmodule
